/* hdl/osel_pkg.sv */
// Shared types and constants for the order statistic select unit.
package osel_pkg;

   localparam int OSEL_DEPTH = 128;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] value;
      logic [7:0]         rank;
   } osel_req_type;

   typedef struct packed {
      logic signed [31:0] selected;
      logic               rank_error;
   } osel_rsp_type;

   // Broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic               load;
      logic               snap;
      logic               shift;
      logic signed [31:0] value;
   } osel_ctl_type;

endpackage

/* hdl/osel_cell.sv */
// One sorting cell: holds one ordered value and one stage of the readout chain.
module osel_cell (
   input  logic                  clock,
   input  osel_pkg::osel_ctl_type ctl,
   input  logic                  occupied,
   input  logic signed [31:0]    prev_val,
   input  logic                  prev_gt,
   input  logic signed [31:0]    next_rd,
   output logic signed [31:0]    val,
   output logic                  gt,
   output logic signed [31:0]    rd
);
   import osel_pkg::*;

   logic signed [31:0] val_ff;
   logic signed [31:0] val_in;
   logic signed [31:0] rd_ff;
   logic signed [31:0] rd_in;

   // An empty cell counts as larger than any incoming value.
   assign gt = ~occupied | (val_ff > ctl.value);

   always_comb begin
      val_in = val_ff;
      if (ctl.load && gt) begin
         // take the left neighbor's value if it moves right, else the new one
         val_in = prev_gt ? prev_val : ctl.value;
      end
   end

   always_comb begin
      rd_in = rd_ff;
      if (ctl.snap) begin
         rd_in = val_ff;
      end else if (ctl.shift) begin
         rd_in = next_rd;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rd_ff  <= rd_in;
   end

   assign val = val_ff;
   assign rd  = rd_ff;

endmodule

/* hdl/order_statistic_select_unit.sv */
// Top level of the order statistic select unit: cell chain plus query sequencer.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries load,
// query and clear commands; a transfer happens when valid is high and stall is
// low. A load inserts a signed value at its sorted place; loads past DEPTH
// entries are dropped. A clear empties the set. Loads and clears give no
// response.
// A query snapshots the sorted chain into a readout shift line and shifts it
// toward cell zero; the rank-th value arrives after rank-1 shifts.
// Loads and clears are taken back to back.
// The response channel (rsp_valid, rsp_stall, rsp_data) has its own output
// register: while a response waits under stall, loads and clears are still
// taken; a further query runs its shift and then holds until the register
// frees. req_stall is high only while a query is in flight.
// Reset (synchronous, active high) empties the set, drops any query in flight
// and any waiting response. Stored values are not cleared.
module order_statistic_select_unit #(
   parameter int DEPTH = osel_pkg::OSEL_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  osel_pkg::osel_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output osel_pkg::osel_rsp_type rsp_data
);
   import osel_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);   // element count
   localparam int IW = $clog2(DEPTH);       // cell index
   localparam int KW = (CW > 8) ? CW : 8;   // rank compare width

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          err_ff, err_in;
   logic          rsp_valid_ff, rsp_valid_in;
   osel_rsp_type  rsp_data_ff, rsp_data_in;

   logic          req_fire;
   logic          is_load, is_query, is_clear;
   logic          store_full;
   logic [KW-1:0] rank_k;
   logic [KW-1:0] count_k;
   logic [KW-1:0] rank_m1;
   logic          rank_bad;
   logic          out_free;
   logic          scan_done;
   osel_ctl_type  ctl;

   logic signed [31:0] val_w [DEPTH];
   logic signed [31:0] rd_w  [DEPTH];
   logic               gt_w  [DEPTH];

   assign req_stall = (state_ff == ST_SCAN);
   assign req_fire  = req_valid & ~req_stall;
   assign is_load   = req_fire & (req_data.opcode == OP_LOAD);
   assign is_query  = req_fire & (req_data.opcode == OP_QUERY);
   assign is_clear  = req_fire & (req_data.opcode == OP_CLEAR);

   assign store_full = (count_ff == CW'(DEPTH));
   assign rank_k     = KW'(req_data.rank);
   assign count_k    = KW'(count_ff);
   assign rank_m1    = rank_k - KW'(1);
   assign rank_bad   = (rank_k == '0) | (rank_k > count_k);

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign scan_done = (state_ff == ST_SCAN) & (cnt_ff == '0) & out_free;

   // Broadcast to the chain: insert on load, snapshot on query, shift while counting.
   assign ctl.load  = is_load & ~store_full;
   assign ctl.snap  = is_query;
   assign ctl.shift = (state_ff == ST_SCAN) & (cnt_ff != '0);
   assign ctl.value = req_data.value;

   // Cell chain; cell zero holds the smallest value.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] prev_val;
      logic               prev_gt;
      logic signed [31:0] next_rd;
      logic               occupied;

      assign occupied = (count_ff > CW'(i));

      if (i == 0) begin : g_first
         assign prev_val = '0;
         assign prev_gt  = 1'b0;
      end else begin : g_rest
         assign prev_val = val_w[i-1];
         assign prev_gt  = gt_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_rd = rd_w[i];
      end else begin : g_inner
         assign next_rd = rd_w[i+1];
      end

      osel_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .occupied (occupied),
         .prev_val (prev_val),
         .prev_gt  (prev_gt),
         .next_rd  (next_rd),
         .val      (val_w[i]),
         .gt       (gt_w[i]),
         .rd       (rd_w[i])
      );
   end

   // Element count: advance on an accepted load, drop to zero on clear.
   always_comb begin
      count_in = count_ff;
      if (is_clear) begin
         count_in = '0;
      end else if (ctl.load) begin
         count_in = count_ff + CW'(1);
      end
   end

   // Query sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_query) begin
               state_in = ST_SCAN;
               err_in   = rank_bad;
               cnt_in   = rank_bad ? '0 : rank_m1[IW-1:0];
            end
         end
         ST_SCAN: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - IW'(1);
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load on scan completion, drop after transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (scan_done) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.selected   = err_ff ? '0 : rd_w[0];
         rsp_data_in.rank_error = err_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/sv/tb_order_statistic_select_unit.sv */
// Self-checking testbench for the order statistic select unit: load/query/clear traffic.
module tb_order_statistic_select_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import osel_pkg::*;

   // Opcode 3 has no name in the package; the unit must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int TOTAL_ITEMS   = 700;
   localparam int CALM_TAIL     = 80;   // final transfers run with no idling on either side
   localparam int LONG_HOLD     = 300;  // receiver hold-off that backs the unit up
   localparam int IDLE_LIMIT    = 4000; // cycles without any transfer before giving up
   // Allow two of the longest queries to drain.
   localparam int SETTLE_CYCLES = 2 * OSEL_DEPTH + 20;

   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   typedef struct {
      osel_req_type cmd;
      bit           typed;  // answer below is written out by hand
      osel_rsp_type answer;
   } script_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   osel_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   osel_rsp_type rsp_data;

   // Shadow of the unit: sorted contents and fill level.
   logic signed [31:0] sorted_set [OSEL_DEPTH];
   int unsigned        set_size = 0;
   osel_rsp_type       awaited_answers [$];
   script_row_type     directed_rows [$];

   // Shared between the request and response sides.
   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;

   int failures      = 0;
   int items_sent    = 0;
   int loads         = 0;
   int dropped_loads = 0;
   int queries       = 0;
   int error_answers = 0;
   int clears        = 0;
   int answers_seen  = 0;
   int unsigned peak_size = 0;

   order_statistic_select_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(string what, logic signed [31:0] got,
                                  logic signed [31:0] want);
      failures++;
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Advance the shadow on every accepted request transfer and queue the
   // answer a query must produce. A hand-written answer replaces the computed one.
   function automatic void apply_command(osel_req_type cmd, bit typed,
                                         osel_rsp_type typed_answer);
      int unsigned  pos;
      osel_rsp_type answer;
      case (cmd.opcode)
         OP_LOAD: begin
            loads++;
            if (set_size >= OSEL_DEPTH) begin
               // Store full: drop the value, no response.
               dropped_loads++;
            end else begin
               // Shift larger entries up and insert; equal values stay in arrival order.
               pos = set_size;
               while (pos > 0 && $signed(sorted_set[pos - 1]) > $signed(cmd.value)) begin
                  sorted_set[pos] = sorted_set[pos - 1];
                  pos--;
               end
               sorted_set[pos] = cmd.value;
               set_size++;
               if (set_size > peak_size) peak_size = set_size;
            end
         end
         OP_QUERY: begin
            queries++;
            if (cmd.rank == 0 || cmd.rank > set_size) begin
               answer.selected   = '0;
               answer.rank_error = 1'b1;
               error_answers++;
            end else begin
               answer.selected   = sorted_set[cmd.rank - 1];
               answer.rank_error = 1'b0;
            end
            awaited_answers.push_back(typed ? typed_answer : answer);
         end
         OP_CLEAR: begin
            clears++;
            set_size = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic void add_row(logic [1:0] op, logic signed [31:0] v, logic [7:0] r,
                                   bit typed, logic signed [31:0] sel, bit err);
      script_row_type row;
      row.cmd    = '{opcode: op, value: v, rank: r};
      row.typed  = typed;
      row.answer = '{selected: sel, rank_error: err};
      directed_rows.push_back(row);
   endfunction

   // Half duplicates and extremes, the rest full-range.
   function automatic logic signed [31:0] pick_value();
      int offset;
      case ($urandom_range(0, 9))
         0: return MOST_NEGATIVE;
         1: return MOST_POSITIVE;
         2, 3, 4: begin
            offset = $urandom_range(0, 16);
            return offset - 8;
         end
         default: return $urandom;
      endcase
   endfunction

   // Mostly in range; zero, one past the count and anything up to the depth too.
   function automatic logic [7:0] pick_rank();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return (set_size >= OSEL_DEPTH) ? 8'(OSEL_DEPTH) : 8'(set_size + 1);
         2: return 8'($urandom_range(0, OSEL_DEPTH));
         default: return (set_size == 0) ? 8'd1 : 8'($urandom_range(1, set_size));
      endcase
   endfunction

   // Offer one command and hold it until the unit takes it. Every caller that
   // waits afterwards must drop valid first, or the command goes in twice.
   task automatic send_item(osel_req_type cmd, bit typed, osel_rsp_type typed_answer);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_command(cmd, typed, typed_answer);
      if (cmd.opcode != OP_UNUSED) items_sent++;
   endtask

   // Fields a command does not use carry random content as well.
   task automatic issue(logic [1:0] op);
      osel_req_type cmd;
      cmd.opcode = op;
      cmd.value  = pick_value();
      cmd.rank   = pick_rank();
      send_item(cmd, 1'b0, '0);
   endtask

   // Clear now and then, stream in loads with queries mixed in, then read back.
   task automatic run_episode(int fill);
      if (set_size + fill > OSEL_DEPTH || $urandom_range(0, 2) == 0) issue(OP_CLEAR);
      for (int n = 0; n < fill; n++) begin
         issue(OP_LOAD);
         if ($urandom_range(0, 3) == 0) issue(OP_QUERY);
         if ($urandom_range(0, 24) == 0) issue(OP_UNUSED);
         if ($urandom_range(0, 59) == 0) issue(OP_CLEAR);
      end
      repeat ($urandom_range(1, 8)) issue(OP_QUERY);
   endtask

   // Response side: random stall bursts, one long hold-off on request.
   initial begin : response_side
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Compare every response transfer with the oldest queued answer, field by field.
   always @(posedge clock) begin : answer_check
      osel_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         answers_seen++;
         if (awaited_answers.size() == 0) begin
            report_mismatch("response with no query pending", rsp_data.selected, '0);
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_data.selected !== want.selected)
               report_mismatch("selected", rsp_data.selected, want.selected);
            if (rsp_data.rank_error !== want.rank_error)
               report_mismatch("rank_error", 32'(rsp_data.rank_error), 32'(want.rank_error));
         end
      end
   end

   // Give up when neither channel has moved for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d answers pending",
               $time, IDLE_LIMIT, awaited_answers.size());
      $display("order_statistic_select_unit: mismatch");
      $finish;
   end

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed script. Out-of-range and extreme answers are written out;
      // the rest come from the shadow.
      //       opcode     value          rank    typed  selected       error
      add_row(OP_QUERY,  32'sd0,        8'd1,   1'b1,  32'sd0,        1'b1); // empty set
      add_row(OP_QUERY,  32'sd0,        8'd0,   1'b1,  32'sd0,        1'b1); // rank zero
      add_row(OP_UNUSED, MOST_NEGATIVE, 8'hFF,  1'b0,  32'sd0,        1'b0); // ignored
      add_row(OP_LOAD,   MOST_POSITIVE, 8'hFF,  1'b0,  32'sd0,        1'b0);
      add_row(OP_LOAD,   MOST_NEGATIVE, 8'd0,   1'b0,  32'sd0,        1'b0);
      add_row(OP_QUERY,  32'sd0,        8'd1,   1'b1,  MOST_NEGATIVE, 1'b0);
      add_row(OP_QUERY,  32'sd0,        8'd2,   1'b1,  MOST_POSITIVE, 1'b0);
      add_row(OP_QUERY,  32'sd0,        8'd3,   1'b1,  32'sd0,        1'b1); // one past count
      add_row(OP_LOAD,   32'sd0,        8'd0,   1'b0,  32'sd0,        1'b0);
      add_row(OP_LOAD,   -32'sd1,       8'd0,   1'b0,  32'sd0,        1'b0);
      add_row(OP_LOAD,   32'sd5,        8'd0,   1'b0,  32'sd0,        1'b0);
      add_row(OP_LOAD,   32'sd5,        8'd0,   1'b0,  32'sd0,        1'b0); // duplicate
      add_row(OP_QUERY,  32'sd0,        8'd3,   1'b0,  32'sd0,        1'b0);
      add_row(OP_QUERY,  32'sd0,        8'd4,   1'b0,  32'sd0,        1'b0);
      add_row(OP_QUERY,  32'sd0,        8'd5,   1'b0,  32'sd0,        1'b0);
      add_row(OP_QUERY,  32'sd0,        8'd6,   1'b0,  32'sd0,        1'b0);
      add_row(OP_QUERY,  MOST_POSITIVE, 8'd0,   1'b1,  32'sd0,        1'b1);
      add_row(OP_QUERY,  32'sd0,        8'd128, 1'b1,  32'sd0,        1'b1); // top rank bit
      add_row(OP_QUERY,  32'sd0,        8'd127, 1'b1,  32'sd0,        1'b1);
      add_row(OP_CLEAR,  MOST_NEGATIVE, 8'd127, 1'b0,  32'sd0,        1'b0);
      add_row(OP_QUERY,  32'sd0,        8'd1,   1'b1,  32'sd0,        1'b1); // after clear
      add_row(OP_LOAD,   32'sd42,       8'd0,   1'b0,  32'sd0,        1'b0);
      add_row(OP_QUERY,  32'sd0,        8'd1,   1'b1,  32'sd42,       1'b0);
      add_row(OP_QUERY,  32'sd0,        8'd2,   1'b1,  32'sd0,        1'b1);
      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].answer);

      // Fill past capacity so the last loads get dropped.
      run_episode(OSEL_DEPTH + 4);

      // Back the unit up: hold the receiver off and keep offering until req_stall rises.
      req_valid <= 1'b0;
      idle_on = 1'b0;
      hold_request = 1'b1;
      while (hold_request) @(posedge clock);
      issue(OP_CLEAR);
      repeat (30) issue(($urandom_range(0, 1) == 0) ? OP_QUERY : OP_LOAD);
      idle_on = 1'b1;

      // Pause the sender until every pending answer has come back.
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);

      // Random traffic: mostly short load/query sequences, now and then a full store.
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= TOTAL_ITEMS - CALM_TAIL) idle_on = 1'b0;
         run_episode(($urandom_range(0, 29) == 0) ? OSEL_DEPTH + 2 : $urandom_range(1, 20));
      end

      // Drain, then watch for stray responses.
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d loads (%0d dropped at a full store, peak fill %0d of %0d),",
               loads, dropped_loads, peak_size, OSEL_DEPTH);
      $display("%0d queries (%0d out of range), %0d clears; %0d responses checked, %0d failures",
               queries, error_answers, clears, answers_seen, failures);
      if (failures == 0)
         $display("order_statistic_select_unit: match");
      else
         $display("order_statistic_select_unit: mismatch");
      $finish;
   end

endmodule
